@@ hdl/cdr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdr_pkg - shared definitions for the captive DNS responder
// Sizes, header rewrite constants, register indexes, the record handed from
// the query parser to the reply sequencer and the answer record table.
// ----------------------------------------------------------------------------
package cdr_pkg;

    // packet limits
    localparam int MAX_QUERY_BYTES = 144;
    localparam int POS_W           = $clog2(MAX_QUERY_BYTES + 1);
    // label offsets reach position + 255 + 1
    localparam int LBL_W           = ((POS_W > 8) ? POS_W : 8) + 1;
    localparam int HDR_LEN         = 12;
    localparam int QTAIL_LEN       = 4;     // QTYPE and QCLASS bytes after the zero
    localparam int ANS_LEN         = 16;
    localparam int ANS_IDX_W       = $clog2(ANS_LEN);

    // header rewrite
    localparam logic [7:0] HDR_FLAGS_SET = 8'h84;  // QR and AA
    localparam logic [7:0] HDR_RA_BYTE   = 8'h80;
    localparam logic [7:0] ANCOUNT_LO    = 8'h01;

    // answer record
    localparam logic [7:0] NAME_PTR_HI = 8'hC0;
    localparam logic [7:0] NAME_PTR_LO = 8'h0C;   // offset of the question name
    localparam logic [7:0] RDLENGTH_LO = 8'h04;

    // configuration
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_ANSWER_ADDRESS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANSWER_TTL     = 1'd1;
    localparam logic [CFG_DATA_W-1:0] ANSWER_ADDRESS_RST = 32'hC0A8_0401;
    localparam logic [CFG_DATA_W-1:0] ANSWER_TTL_RST     = 32'd60;

    // per byte record: optional reply byte, then the packet end work
    typedef struct packed {
        logic       valid;  // record carries at least one beat
        logic       emit;   // data is a reply byte
        logic [7:0] data;
        logic       last;   // packet ends: answer or discard follows
        logic       ok;     // query well formed
    } rec_t;

    // byte idx of the appended A record
    function automatic logic [7:0] answer_byte(
        input logic [ANS_IDX_W-1:0]  idx,
        input logic [CFG_DATA_W-1:0] ttl,
        input logic [CFG_DATA_W-1:0] addr
    );
        logic [7:0] b;
        case (idx)
            4'd0:    b = NAME_PTR_HI;
            4'd1:    b = NAME_PTR_LO;
            4'd3:    b = 8'h01;        // type A
            4'd5:    b = 8'h01;        // class IN
            4'd6:    b = ttl[31:24];
            4'd7:    b = ttl[23:16];
            4'd8:    b = ttl[15:8];
            4'd9:    b = ttl[7:0];
            4'd11:   b = RDLENGTH_LO;
            4'd12:   b = addr[31:24];
            4'd13:   b = addr[23:16];
            4'd14:   b = addr[15:8];
            4'd15:   b = addr[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

@@ hdl/cdr_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdr_parser - per byte query walk
// Rewrites the header, follows the question name by its label lengths and
// decides on packet end whether the query is well formed.
// ----------------------------------------------------------------------------
module cdr_parser
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            take,        // input beat accepted
    input  logic [7:0]      query_byte,
    input  logic            end_of_packet,
    output cdr_pkg::rec_t   rec
);
    import cdr_pkg::*;

    logic [POS_W-1:0] pos_reg,   pos_next;
    logic [LBL_W-1:0] lbl_reg,   lbl_next;
    logic [POS_W-1:0] end_reg,   end_next;
    logic             found_reg, found_next;
    logic             in_range;
    logic             emit;
    logic [7:0]       obyte;
    logic             ok;

    assign in_range = pos_reg < POS_W'(MAX_QUERY_BYTES);

    // byte work and next walk state
    always_comb
    begin
        pos_next   = pos_reg;
        lbl_next   = lbl_reg;
        end_next   = end_reg;
        found_next = found_reg;
        emit       = in_range;
        obyte      = query_byte;
        if (in_range)
        begin
            if (pos_reg < POS_W'(HDR_LEN))
            begin
                // header rewrite
                if (pos_reg == POS_W'(2))
                    obyte = query_byte | HDR_FLAGS_SET;
                else if (pos_reg == POS_W'(3))
                    obyte = HDR_RA_BYTE;
                else if (pos_reg == POS_W'(6))
                    obyte = 8'h00;
                else if (pos_reg == POS_W'(7))
                    obyte = ANCOUNT_LO;
                else if (pos_reg >= POS_W'(8))
                    obyte = 8'h00;
            end
            else if (!found_reg)
            begin
                // name walk
                if (LBL_W'(pos_reg) == lbl_reg)
                begin
                    if (query_byte == 8'h00)
                    begin
                        found_next = 1'b1;
                        end_next   = pos_reg;
                    end
                    else
                    begin
                        lbl_next = LBL_W'(pos_reg) + LBL_W'(query_byte) + LBL_W'(1);
                    end
                end
            end
            else if ({1'b0, pos_reg} > ({1'b0, end_reg} + (POS_W+1)'(QTAIL_LEN)))
            begin
                emit = 1'b0;    // past QTYPE/QCLASS
            end
            pos_next = pos_reg + POS_W'(1);
        end

        ok = (pos_next >= POS_W'(HDR_LEN)) && found_next &&
             (({1'b0, end_next} + (POS_W+1)'(QTAIL_LEN + 1)) <= {1'b0, pos_next});

        // packet end returns the walk to its start
        if (end_of_packet)
        begin
            pos_next   = '0;
            lbl_next   = LBL_W'(HDR_LEN);
            end_next   = '0;
            found_next = 1'b0;
        end
    end

    assign rec.valid = emit || end_of_packet;
    assign rec.emit  = emit;
    assign rec.data  = obyte;
    assign rec.last  = end_of_packet;
    assign rec.ok    = ok;

    // walk state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            lbl_reg   <= LBL_W'(HDR_LEN);
            end_reg   <= '0;
            found_reg <= 1'b0;
        end
        else if (take)
        begin
            pos_reg   <= pos_next;
            lbl_reg   <= lbl_next;
            end_reg   <= end_next;
            found_reg <= found_next;
        end
    end

endmodule

@@ hdl/captive_dns_responder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// captive_dns_responder - answers well-formed DNS queries with one A record
// Streams the query back with its header rewritten and the question kept,
// then appends a 16-byte A record or, for a malformed query, a discard beat.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake            | content
//  ---------+-----+----------------------+-----------------------------------
//  s_axis   | in  | s_tvalid / s_tready  | query_byte, end_of_packet (tlast)
//  m_axis   | out | m_tvalid / m_tready  | reply_byte, end_of_reply (tlast),
//           |     |                      | discard (tuser)
//  cfg      | in  | cfg_valid / cfg_ready| register index, 32-bit data
//
// One query byte a cycle while s_tready is high; each echoed byte leaves as a
// reply beat from the record register. The record of the last byte of a packet
// spans up to 17 beats (its reply byte and the 16 answer beats) or up to 2
// (discard), so the input waits while the answer sequencer sends them.
// Reset clears the name walk and loads the default address and TTL.
// A stalled output holds the record; the input takes a new beat in the same
// cycle the last beat of the held record leaves.
// ----------------------------------------------------------------------------
module captive_dns_responder
(
    input  logic                           clk,
    input  logic                           rst_n,
    // query stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] query_byte
    input  logic                           s_tlast,   // end_of_packet
    // reply stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,   // [7:0] reply_byte
    output logic                           m_tlast,   // end_of_reply
    output logic                           m_tuser,   // [0] discard
    // configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cdr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cdr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import cdr_pkg::*;

    logic [CFG_DATA_W-1:0] addr_reg;
    logic [CFG_DATA_W-1:0] ttl_reg;

    rec_t                  rec;
    logic                  take;
    logic                  load;
    logic                  beat;
    logic                  final_beat;

    logic                  rec_valid_reg;
    logic                  rec_emit_reg;
    logic [7:0]            rec_data_reg;
    logic                  rec_last_reg;
    logic                  rec_ok_reg;
    logic [ANS_IDX_W-1:0]  ans_idx_reg;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= ANSWER_ADDRESS_RST;
            ttl_reg  <= ANSWER_TTL_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ANSWER_ADDRESS: addr_reg <= cfg_data;
                REG_ANSWER_TTL:     ttl_reg  <= cfg_data;
                default:            ;
            endcase
        end
    end

    // query walk
    assign take = s_tvalid && s_tready;

    cdr_parser u_parser
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .query_byte    (s_tdata),
        .end_of_packet (s_tlast),
        .rec           (rec)
    );

    // record register and answer sequencer
    assign beat       = m_tvalid && m_tready;
    assign final_beat = rec_emit_reg ? !rec_last_reg
                                     : (!rec_ok_reg || (ans_idx_reg == ANS_IDX_W'(ANS_LEN - 1)));
    assign s_tready   = !rec_valid_reg || (beat && final_beat);
    assign load       = take && rec.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_valid_reg <= 1'b0;
            rec_emit_reg  <= 1'b0;
            ans_idx_reg   <= '0;
        end
        else if (load)
        begin
            rec_valid_reg <= 1'b1;
            rec_emit_reg  <= rec.emit;
            ans_idx_reg   <= '0;
        end
        else if (beat && final_beat)
        begin
            rec_valid_reg <= 1'b0;
            ans_idx_reg   <= '0;
        end
        else if (beat)
        begin
            if (rec_emit_reg)
                rec_emit_reg <= 1'b0;       // reply byte out, answer or discard next
            else
                ans_idx_reg <= ans_idx_reg + ANS_IDX_W'(1);
        end
    end

    // record payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rec_data_reg <= rec.data;
            rec_last_reg <= rec.last;
            rec_ok_reg   <= rec.ok;
        end
    end

    // reply beat
    assign m_tvalid = rec_valid_reg;
    assign m_tdata  = rec_emit_reg ? rec_data_reg
                    : (rec_ok_reg ? answer_byte(ans_idx_reg, ttl_reg, addr_reg) : 8'h00);
    assign m_tlast  = !rec_emit_reg &&
                      (!rec_ok_reg || (ans_idx_reg == ANS_IDX_W'(ANS_LEN - 1)));
    assign m_tuser  = !rec_emit_reg && !rec_ok_reg;

    // checks
    a_discard_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tlast && (m_tdata == 8'h00)))
        else $error("discard beat not a zero final beat");

    a_answer_idx_state: assert property (@(posedge clk) disable iff (!rst_n)
        (ans_idx_reg != '0) |-> (rec_valid_reg && !rec_emit_reg && rec_ok_reg && rec_last_reg))
        else $error("answer index running outside an answer");

    a_answer_runs_on: assert property (@(posedge clk) disable iff (!rst_n)
        (beat && !rec_emit_reg && rec_ok_reg && !final_beat) |=>
        (m_tvalid && !m_tuser && (ans_idx_reg == $past(ans_idx_reg) + ANS_IDX_W'(1))))
        else $error("answer record broken off");

    a_no_take_mid_record: assert property (@(posedge clk) disable iff (!rst_n)
        (rec_valid_reg && !(beat && final_beat)) |-> !s_tready)
        else $error("input taken while a record is pending");

endmodule
